// File: rtl/core/wsj_pkg.sv
package wsj_pkg;

  localparam int LANES           = 4;
  localparam int NPORTS_DEF      = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int ADM_W      = 16;
  localparam int COUP_W     = 11;
  localparam int OVR_LANE_W = 12;
  localparam int LOSS_W     = 10;
  localparam int MASK_W     = 4;
  localparam int SUMY_W     = ADM_W + $clog2(LANES);

  localparam int ONE_Q10     = 1024;
  localparam int Q10_SHIFT   = 10;
  localparam int LOSS_CAP    = 1013;
  localparam int SCALE_SHIFT = 20;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ENABLED    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ADMIT      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUPLE_OVR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COUPLE_GLB = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOSS       = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_SUM,
    S_DIV,
    S_MIX,
    S_SCALE,
    S_ROUND
  } state_t;

  typedef enum logic [1:0] {
    M_IDLE,
    M_PREP,
    M_DIV,
    M_FIN
  } merge_state_t;

  typedef struct packed {
    logic prod_en;
    logic mix_en;
    logic scale_en;
    logic round_en;
  } lane_ctrl_t;

endpackage

// File: rtl/core/waveguide_scattering_junction_unit.sv
// channel   dir  signals                          transfer when
// s_axis    in   s_axis_tvalid/tready/tdata       tvalid & tready
// m_axis    out  m_axis_tvalid/tready/tdata       tvalid & tready
// apb       in   psel/penable/pwrite/paddr/pwdata write: psel & penable & pwrite & pready
//
// one item at a time: each item passes through the shared restoring divider
// in wsj_merge, one quotient bit per cycle.
// every transfer in returns the results of the item before it; the first one
// after reset returns zeros. rst is synchronous and clears results and control.
// a result waits in the output register, a second in a skid register, while
// the next item computes; s_axis_tready is high only in idle with the skid empty.
module waveguide_scattering_junction_unit import wsj_pkg::*; #(
  parameter int NPORTS      = NPORTS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // sample_port0, sample_port1, sample_port2, sample_port3, zero fill
  input  logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_port0, out_port1, out_port2, out_port3, zero fill
  output logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int TDATA_W = ((LANES * SAMPLE_BITS + 7) / 8) * 8;
  localparam int PW      = SAMPLE_BITS + ADM_W + 1;

  localparam logic [LANES*ADM_W-1:0] ADMIT_RST = {LANES{16'h0100}};

  logic [MASK_W-1:0]           enabled_mask;
  logic [LANES*ADM_W-1:0]      port_admittances;
  logic [LANES*OVR_LANE_W-1:0] coupling_overrides;
  logic [COUP_W-1:0]           coupling_global;
  logic [LOSS_W-1:0]           loss_factor;

  logic                        cfg_wr;
  logic [REG_IDX_W-1:0]        reg_idx;
  logic [COUP_W-1:0]           cg_eff;
  logic [LOSS_W-1:0]           loss_eff;
  logic [COUP_W-1:0]           loss_mul;

  state_t                      state;
  state_t                      state_next;
  lane_ctrl_t                  ctrl;
  logic                        start;
  logic                        p_done;
  logic signed [SAMPLE_BITS:0] p;

  logic                        s_accept;
  logic                        out_free;
  logic                        pend;
  logic [TDATA_W-1:0]          snap;
  logic [TDATA_W-1:0]          res_packed;

  logic signed [SAMPLE_BITS-1:0] a   [LANES];
  logic signed [PW-1:0]          prod [LANES];
  logic signed [SAMPLE_BITS-1:0] res [LANES];
  logic [LANES-1:0]              lane_en;

  // configuration
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_mask       <= MASK_W'(4'hF);
      port_admittances   <= ADMIT_RST;
      coupling_overrides <= '0;
      coupling_global    <= COUP_W'(ONE_Q10);
      loss_factor        <= LOSS_W'(51);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ENABLED:    enabled_mask       <= pwdata[MASK_W-1:0];
        REG_ADMIT:      port_admittances   <= pwdata[LANES*ADM_W-1:0];
        REG_COUPLE_OVR: coupling_overrides <= pwdata[LANES*OVR_LANE_W-1:0];
        REG_COUPLE_GLB: coupling_global    <= pwdata[COUP_W-1:0];
        REG_LOSS:       loss_factor        <= pwdata[LOSS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLED:    prdata = CFG_DATA_W'(enabled_mask);
      REG_ADMIT:      prdata = CFG_DATA_W'(port_admittances);
      REG_COUPLE_OVR: prdata = CFG_DATA_W'(coupling_overrides);
      REG_COUPLE_GLB: prdata = CFG_DATA_W'(coupling_global);
      REG_LOSS:       prdata = CFG_DATA_W'(loss_factor);
      default:        prdata = '0;
    endcase
  end

  assign cg_eff   = (coupling_global > COUP_W'(ONE_Q10)) ? COUP_W'(ONE_Q10) : coupling_global;
  assign loss_eff = (loss_factor > LOSS_W'(LOSS_CAP)) ? LOSS_W'(LOSS_CAP) : loss_factor;
  assign loss_mul = COUP_W'(ONE_Q10) - COUP_W'(loss_eff);

  // sequencer
  assign s_axis_tready = (state == S_IDLE) && !pend;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    start      = 1'b0;
    unique case (state)
      S_IDLE: if (s_accept) state_next = S_PROD;
      S_PROD: begin
        ctrl.prod_en = 1'b1;
        state_next   = S_SUM;
      end
      S_SUM: begin
        start      = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: if (p_done) state_next = S_MIX;
      S_MIX: begin
        ctrl.mix_en = 1'b1;
        state_next  = S_SCALE;
      end
      S_SCALE: begin
        ctrl.scale_en = 1'b1;
        state_next    = S_ROUND;
      end
      S_ROUND: begin
        ctrl.round_en = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      for (int k = 0; k < LANES; k++) begin
        a[k] <= s_axis_tdata[k*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
  end

  // port lanes
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    if (k < NPORTS) begin : g_on
      assign lane_en[k] = enabled_mask[k];
      wsj_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .en       (lane_en[k]),
        .adm      (port_admittances[k*ADM_W +: ADM_W]),
        .ovr      (coupling_overrides[k*OVR_LANE_W +: OVR_LANE_W]),
        .coup_glb (cg_eff),
        .loss_mul (loss_mul),
        .a        (a[k]),
        .p        (p),
        .prod     (prod[k]),
        .res      (res[k])
      );
    end else begin : g_off
      assign lane_en[k] = 1'b0;
      assign prod[k]    = '0;
      assign res[k]     = '0;
    end
  end

  wsj_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .en    (lane_en),
    .adm   (port_admittances),
    .prod  (prod),
    .done  (p_done),
    .p     (p)
  );

  // output register with skid
  always_comb begin
    res_packed = '0;
    for (int k = 0; k < LANES; k++) begin
      res_packed[k*SAMPLE_BITS +: SAMPLE_BITS] = res[k];
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      pend          <= 1'b0;
    end else if (s_accept) begin
      if (out_free) begin
        m_axis_tvalid <= 1'b1;
      end else begin
        pend <= 1'b1;
      end
    end else if (pend && out_free) begin
      m_axis_tvalid <= 1'b1;
      pend          <= 1'b0;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && out_free) begin
      m_axis_tdata <= res_packed;
    end else if (pend && out_free) begin
      m_axis_tdata <= snap;
    end
    if (s_accept && !out_free) begin
      snap <= res_packed;
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    p_done |-> state == S_DIV)
    else $error("junction pressure ready outside divide phase");

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> m_axis_tvalid)
    else $error("accepted transfer left no result pending");

  a_skid_backed: assert property (@(posedge clk) disable iff (rst)
    pend |-> m_axis_tvalid)
    else $error("skid holds a result while output register is empty");

  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && !lane_en[0]) |=> res[0] == '0)
    else $error("disabled port produced a nonzero result");
`endif

endmodule

// File: rtl/core/wsj_lane.sv
module wsj_lane import wsj_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lane_ctrl_t                    ctrl,
  input  logic                          en,
  input  logic [ADM_W-1:0]              adm,
  input  logic [OVR_LANE_W-1:0]         ovr,
  input  logic [COUP_W-1:0]             coup_glb,
  input  logic [COUP_W-1:0]             loss_mul,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic signed [SAMPLE_BITS:0]   p,
  output logic signed [SAMPLE_BITS+ADM_W:0] prod,
  output logic signed [SAMPLE_BITS-1:0] res
);

  localparam int PW  = SAMPLE_BITS + ADM_W + 1;
  localparam int DFW = SAMPLE_BITS + 2;
  localparam int MW  = SAMPLE_BITS + 14;
  localparam int YW  = MW + COUP_W + 1;

  localparam logic signed [YW-1:0] RND_HALF = $signed(YW'(1) << (SCALE_SHIFT - 1));
  localparam logic signed [YW-1:0] SAT_HI   =
    $signed(YW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1));
  localparam logic signed [YW-1:0] SAT_LO   = ~SAT_HI;

  logic [COUP_W-1:0]         c;
  logic signed [COUP_W:0]    c_s;
  logic signed [COUP_W:0]    lm_s;
  logic signed [ADM_W:0]     adm_s;
  logic signed [DFW-1:0]     diff;
  logic signed [MW-1:0]      mix_next;
  logic signed [MW-1:0]      mix;
  logic signed [YW-1:0]      scaled;
  logic signed [YW-1:0]      rnd;
  logic signed [YW-1:0]      shr;
  logic signed [SAMPLE_BITS-1:0] sat_val;

  // per-port coupling: override when its flag is set, capped at unity
  always_comb begin
    if (ovr[OVR_LANE_W-1]) begin
      c = (ovr[COUP_W-1:0] > COUP_W'(ONE_Q10)) ? COUP_W'(ONE_Q10) : ovr[COUP_W-1:0];
    end else begin
      c = coup_glb;
    end
  end

  assign c_s   = $signed({1'b0, c});
  assign lm_s  = $signed({1'b0, loss_mul});
  assign adm_s = $signed({1'b0, adm});
  assign diff  = DFW'(p) - DFW'(a);

  // (1-c)*a + c*(2p-a) == a + 2c*(p-a)
  assign mix_next = (MW'(a) <<< Q10_SHIFT) + ((MW'(diff) * MW'(c_s)) <<< 1);

  // round half away from zero, then saturate
  always_comb begin
    rnd = scaled + RND_HALF - $signed(YW'(scaled[YW-1]));
    shr = rnd >>> SCALE_SHIFT;
    if (shr > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shr < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_val = shr[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= en ? PW'(adm_s) * PW'(a) : '0;
    end
    if (ctrl.mix_en) begin
      mix <= mix_next;
    end
    if (ctrl.scale_en) begin
      scaled <= YW'(mix) * YW'(lm_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else if (ctrl.round_en) begin
      res <= en ? sat_val : '0;
    end
  end

endmodule

// File: rtl/core/wsj_merge.sv
module wsj_merge import wsj_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [LANES-1:0]                   en,
  input  logic [LANES*ADM_W-1:0]             adm,
  input  logic signed [SAMPLE_BITS+ADM_W:0]  prod [LANES],
  output logic                               done,
  output logic signed [SAMPLE_BITS:0]        p
);

  localparam int PW = SAMPLE_BITS + ADM_W + 1;
  localparam int SW = PW + 2;
  localparam int NW = SAMPLE_BITS + 18;
  localparam int QW = SAMPLE_BITS;
  localparam int CW = $clog2(QW + 1);

  merge_state_t        mstate;
  merge_state_t        mstate_next;
  logic signed [SW-1:0] sum_ya;
  logic signed [SW-1:0] sya_next;
  logic [SUMY_W-1:0]   sum_y;
  logic [SUMY_W-1:0]   sy_next;
  logic [NW-1:0]       mag;
  logic [NW-1:0]       rem;
  logic [NW-1:0]       dsh;
  logic [QW-1:0]       quo;
  logic [CW-1:0]       cnt;
  logic                neg;
  logic                zero;

  always_comb begin
    sya_next = '0;
    sy_next  = '0;
    for (int k = 0; k < LANES; k++) begin
      sya_next = sya_next + SW'(prod[k]);
      if (en[k]) begin
        sy_next = sy_next + SUMY_W'(adm[k*ADM_W +: ADM_W]);
      end
    end
  end

  assign mag  = sum_ya[SW-1] ? NW'(-sum_ya) : NW'(sum_ya);
  assign done = (mstate == M_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
    end else begin
      mstate <= mstate_next;
    end
  end

  always_comb begin
    mstate_next = mstate;
    unique case (mstate)
      M_IDLE: if (start) mstate_next = M_PREP;
      M_PREP: mstate_next = M_DIV;
      M_DIV:  if (cnt == CW'(1)) mstate_next = M_FIN;
      M_FIN:  mstate_next = M_IDLE;
      default: mstate_next = M_IDLE;
    endcase
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    case (mstate)
      M_IDLE: begin
        if (start) begin
          sum_ya <= sya_next;
          sum_y  <= sy_next;
        end
      end
      M_PREP: begin
        neg  <= sum_ya[SW-1];
        zero <= (sum_y == '0);
        rem  <= mag + NW'(sum_y >> 1);
        dsh  <= NW'(sum_y) << (QW - 1);
        quo  <= '0;
        cnt  <= CW'(QW);
      end
      M_DIV: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          quo <= {quo[QW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - CW'(1);
      end
      M_FIN: begin
        if (zero) begin
          p <= '0;
        end else if (neg) begin
          p <= -$signed({1'b0, quo});
        end else begin
          p <= $signed({1'b0, quo});
        end
      end
      default: ;
    endcase
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wsj_pkg::*;

  localparam int DW = ((LANES * SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int SW = SAMPLE_BITS_DEF;
  localparam longint SAMP_MAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint SAMP_MIN = -SAMP_MAX - 1;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  logic [MASK_W-1:0] cfg_mask = 4'hF;
  logic [63:0] cfg_adm = 64'h0100_0100_0100_0100;
  logic [47:0] cfg_ovr = '0;
  logic [COUP_W-1:0] cfg_glb = 11'd1024;
  logic [LOSS_W-1:0] cfg_loss = 10'd51;

  logic [DW-1:0] sample_q[$];
  logic [DW-1:0] junction_q[$];
  logic [DW-1:0] held_out = '0;
  int send_idle = 8;
  int recv_idle = 60;
  int errors = 0;
  int cycle_cnt = 0;

  waveguide_scattering_junction_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic longint round_div(input longint num, input longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + longint'(den / 2)) / longint'(den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [SW-1:0] saturate(input longint v);
    longint r;
    r = (v > SAMP_MAX) ? SAMP_MAX : ((v < SAMP_MIN) ? SAMP_MIN : v);
    return r[SW-1:0];
  endfunction

  function automatic logic [DW-1:0] junction_out(input logic [DW-1:0] din);
    longint a[LANES];
    longint sum_y;
    longint sum_ya;
    longint y;
    longint p;
    longint loss;
    longint cg;
    longint c;
    longint mix;
    logic [OVR_LANE_W-1:0] lane;
    logic [DW-1:0] r;
    r = '0;
    sum_y = 0;
    sum_ya = 0;
    p = 0;
    loss = (cfg_loss > LOSS_CAP) ? LOSS_CAP : longint'(cfg_loss);
    cg = (cfg_glb > ONE_Q10) ? ONE_Q10 : longint'(cfg_glb);
    for (int k = 0; k < LANES; k++) begin
      a[k] = $signed(din[SW*k +: SW]);
      if (cfg_mask[k]) begin
        y = longint'(cfg_adm[ADM_W*k +: ADM_W]);
        sum_y += y;
        sum_ya += y * a[k];
      end
    end
    if (sum_y != 0) begin
      p = round_div(sum_ya, sum_y);
    end
    for (int k = 0; k < LANES; k++) begin
      if (cfg_mask[k]) begin
        lane = cfg_ovr[OVR_LANE_W*k +: OVR_LANE_W];
        c = cg;
        if (lane[OVR_LANE_W-1]) begin
          c = (lane[COUP_W-1:0] > ONE_Q10) ? ONE_Q10 : longint'(lane[COUP_W-1:0]);
        end
        mix = (ONE_Q10 - c) * a[k] + c * (2 * p - a[k]);
        r[SW*k +: SW] = saturate(round_div((ONE_Q10 - loss) * mix,
                                           longint'(1) << SCALE_SHIFT));
      end
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] rand_sample();
    logic [SW-1:0] v;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      1: v = 16'($signed($urandom_range(0, 512)) - 256);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [ADM_W-1:0] rand_admittance();
    logic [ADM_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1, 2, 3: v = 16'($urandom_range(1, 16'h0200));
      4, 5: v = 16'($urandom_range(1, 16'h6400));
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (sample_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        s_axis_tdata <= sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // junction prediction on each input transfer, one item late
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      junction_q.push_back(held_out);
      held_out = junction_out(s_axis_tdata);
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // result monitor
  always @(posedge clk) begin
    logic [DW-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (junction_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, expected none, actual %h",
                 $time, m_axis_tdata);
      end else begin
        want = junction_q.pop_front();
        for (int k = 0; k < LANES; k++) begin
          if (m_axis_tdata[SW*k +: SW] !== want[SW*k +: SW]) begin
            errors++;
            $display("%0t: out_port%0d mismatch, expected %0d, actual %0d", $time, k,
                     $signed(want[SW*k +: SW]), $signed(m_axis_tdata[SW*k +: SW]));
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ENABLED: cfg_mask = val[MASK_W-1:0];
      REG_ADMIT: cfg_adm = val;
      REG_COUPLE_OVR: cfg_ovr = val[47:0];
      REG_COUPLE_GLB: cfg_glb = val[COUP_W-1:0];
      REG_LOSS: cfg_loss = val[LOSS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_samples(input logic [SW-1:0] s0, input logic [SW-1:0] s1,
                              input logic [SW-1:0] s2, input logic [SW-1:0] s3);
    sample_q.push_back({s3, s2, s1, s0});
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
    end while (sample_q.size() != 0 || s_axis_tvalid || junction_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    write_reg(REG_ENABLED, 64'($urandom_range(0, 15)));
    write_reg(REG_ADMIT, {rand_admittance(), rand_admittance(),
                          rand_admittance(), rand_admittance()});
    write_reg(REG_COUPLE_OVR, {16'($urandom), 32'($urandom)});
    write_reg(REG_COUPLE_GLB, ($urandom_range(0, 3) == 0) ?
              64'($urandom_range(0, 2047)) : 64'($urandom_range(0, ONE_Q10)));
    write_reg(REG_LOSS, 64'($urandom_range(0, 1023)));
  endtask

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) begin
      push_samples(rand_sample(), rand_sample(), rand_sample(), rand_sample());
      if (i == n / 2) begin
        drain();
      end
    end
    drain();
  endtask

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("[waveguide_scattering_junction_unit] ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset configuration
    push_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_samples(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_samples(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_samples(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    push_samples(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    push_samples(16'h0001, 16'hFFFF, 16'h0000, 16'h0000);
    drain();

    // no port enabled
    write_reg(REG_ENABLED, 64'h0);
    push_samples(16'h7FFF, 16'h8000, 16'h1234, 16'hFEDC);
    push_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    drain();

    // zero admittance sum
    write_reg(REG_ENABLED, 64'hF);
    write_reg(REG_ADMIT, 64'h0);
    push_samples(16'h7FFF, 16'h8000, 16'h4000, 16'hC000);
    push_samples(16'h0100, 16'hFF00, 16'h0001, 16'hFFFF);
    drain();

    // largest admittances
    write_reg(REG_ADMIT, 64'hFFFF_FFFF_FFFF_FFFF);
    push_samples(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    push_samples(16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
    drain();

    // mixed admittances, mask written with upper bits set
    write_reg(REG_ADMIT, 64'h6400_0001_0000_FFFF);
    write_reg(REG_ENABLED, 64'hFFFF_FFFF_FFFF_FFF5);
    push_samples(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_samples(16'h7FFF, 16'h0000, 16'h8000, 16'h8000);
    drain();

    // coupling overrides, some above one, zero global coupling, no loss
    write_reg(REG_ENABLED, 64'hF);
    write_reg(REG_ADMIT, 64'h0100_0200_0080_6400);
    write_reg(REG_COUPLE_OVR, {12'hA00, 12'h400, 12'h800, 12'hFFF});
    write_reg(REG_COUPLE_GLB, 64'h0);
    write_reg(REG_LOSS, 64'h0);
    push_samples(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    push_samples(16'h7FFF, 16'h8000, 16'h0001, 16'h7FFF);
    drain();

    // global coupling above one, loss above the cap, wide values
    write_reg(REG_COUPLE_OVR, 64'hFFFF_0000_0000_0000);
    write_reg(REG_COUPLE_GLB, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_LOSS, 64'hFFFF_FFFF_FFFF_FFFF);
    push_samples(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    push_samples(16'h1234, 16'hEDCB, 16'h0000, 16'h7FFF);
    drain();

    // loss at the cap, write to an unused register
    write_reg(REG_COUPLE_GLB, 64'd1024);
    write_reg(REG_LOSS, 64'd1013);
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    push_samples(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    push_samples(16'h8000, 16'h0000, 16'h7FFF, 16'h0000);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 8 : ((ph == 1) ? 60 : 0);
      recv_idle = (ph == 0) ? 60 : ((ph == 1) ? 8 : 0);
      for (int seg = 0; seg < 5; seg++) begin
        random_config();
        random_run(100);
      end
    end

    if (errors == 0 && junction_q.size() == 0) begin
      $display("[waveguide_scattering_junction_unit] OK");
    end else begin
      $display("[waveguide_scattering_junction_unit] ERROR");
    end
    $finish;
  end

endmodule
